### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/ipv4p_pkg.sv
// ----------------------------------------------------------------------------
// ipv4p_pkg
// Shared types and constants of the dotted IPv4 text parser.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int OUT_DEPTH   = 2;
    localparam int OUT_AW      = $clog2(OUT_DEPTH);
    localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in;

    typedef struct packed {
        logic        address_valid;
        logic [31:0] address;
    } t_out;

    typedef enum logic [2:0] {
        CL_DIGIT  = 3'd0,
        CL_HEXLET = 3'd1,
        CL_X      = 3'd2,
        CL_DOT    = 3'd3,
        CL_END    = 3'd4,
        CL_OTHER  = 3'd5
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [3:0] val;
        logic       last;
    } t_item;

    typedef enum logic [3:0] {
        PH_START = 4'b0001,
        PH_ZERO  = 4'b0010,
        PH_NUM   = 4'b0100,
        PH_DONE  = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } t_radix;

    typedef struct packed {
        logic       big;
        logic [7:0] val;
    } t_part;

endpackage

### rtl/ipv4_dotted_text_parser.sv
// ----------------------------------------------------------------------------
// ipv4_dotted_text_parser: one character request per cycle while not full.
// A result is registered in the result queue when the engine takes the last
// character from the request queue. The accumulator is a shift-add per digit.
// Synchronous active-low reset empties both queues and restarts the parse.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv4_dotted_text_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    input  ipv4p_pkg::t_in  i_req,
    output logic            full,
    output logic            empty,
    input  logic            pop,
    output ipv4p_pkg::t_out o_res
);

    logic             w_q_valid;
    logic             w_take;
    ipv4p_pkg::t_item w_item;

    ipv4p_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_req   (i_req),
        .full    (full),
        .o_valid (w_q_valid),
        .o_item  (w_item),
        .i_take  (w_take)
    );

    ipv4p_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_item    (w_item),
        .o_take    (w_take),
        .pop       (pop),
        .empty     (empty),
        .o_res     (o_res)
    );

    `ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, push && !full, w_q_valid, "request lost in queue")
    `ASSERT_IMPL(a_take_valid, i_clk, i_rst_n, !w_q_valid, !w_take, "engine took from empty queue")
    `ASSERT_NEXT(a_no_phantom, i_clk, i_rst_n, empty && !(w_take && w_item.last), empty, "result without last char")
    `ASSERT_IMPL(a_invalid_zero, i_clk, i_rst_n, !empty && !o_res.address_valid, o_res.address == 32'd0, "invalid result carries address")

endmodule

### rtl/ipv4p_front.sv
// ----------------------------------------------------------------------------
// ipv4p_front
// Character classifier and request queue feeding the parse engine.
// ----------------------------------------------------------------------------
module ipv4p_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  ipv4p_pkg::t_in   i_req,
    output logic             full,
    output logic             o_valid,
    output ipv4p_pkg::t_item o_item,
    input  logic             i_take
);

    function automatic ipv4p_pkg::t_item classify(input ipv4p_pkg::t_in req);
        ipv4p_pkg::t_item it;
        logic [7:0]       c;
        c       = req.char_code;
        it.last = req.last_char;
        it.val  = c[3:0];
        if (c >= 8'h30 && c <= 8'h39) begin
            it.cls = ipv4p_pkg::CL_DIGIT;
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            it.cls = ipv4p_pkg::CL_HEXLET;
            it.val = c[3:0] + 4'd9;
        end else if (c == 8'h78 || c == 8'h58) begin
            it.cls = ipv4p_pkg::CL_X;
        end else if (c == 8'h2e) begin
            it.cls = ipv4p_pkg::CL_DOT;
        end else if (c == 8'h00 || c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)) begin
            it.cls = ipv4p_pkg::CL_END;
        end else begin
            it.cls = ipv4p_pkg::CL_OTHER;
        end
        return it;
    endfunction

    ipv4p_pkg::t_item                    r_q [ipv4p_pkg::QUEUE_DEPTH];
    logic [ipv4p_pkg::QUEUE_AW-1:0]      r_wp, n_wp;
    logic [ipv4p_pkg::QUEUE_AW-1:0]      r_rp, n_rp;
    logic [ipv4p_pkg::QCNT_W-1:0]        r_cnt, n_cnt;
    logic                                w_push;
    logic                                w_pop;

    assign full    = (r_cnt == ipv4p_pkg::QCNT_W'(ipv4p_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];
    assign w_push  = push && !full;
    assign w_pop   = i_take && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = (r_wp == ipv4p_pkg::QUEUE_AW'(ipv4p_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_pop) begin
            n_rp = (r_rp == ipv4p_pkg::QUEUE_AW'(ipv4p_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= classify(i_req);
        end
    end

endmodule

### rtl/ipv4p_engine.sv
// ----------------------------------------------------------------------------
// ipv4p_engine
// Parse state machine, number accumulator and result queue.
// ----------------------------------------------------------------------------
module ipv4p_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  ipv4p_pkg::t_item i_item,
    output logic             o_take,
    input  logic             pop,
    output logic             empty,
    output ipv4p_pkg::t_out  o_res
);

    function automatic ipv4p_pkg::t_out assemble(
        input logic [31:0]     v,
        input ipv4p_pkg::t_part p0,
        input ipv4p_pkg::t_part p1,
        input ipv4p_pkg::t_part p2,
        input logic [1:0]      cnt
    );
        ipv4p_pkg::t_out r;
        case (cnt)
            2'd0: begin
                r.address_valid = 1'b1;
                r.address       = v;
            end
            2'd1: begin
                r.address_valid = (v[31:24] == '0) && !p0.big;
                r.address       = {p0.val, v[23:0]};
            end
            2'd2: begin
                r.address_valid = (v[31:16] == '0) && !p0.big && !p1.big;
                r.address       = {p0.val, p1.val, v[15:0]};
            end
            default: begin
                r.address_valid = (v[31:8] == '0) && !p0.big && !p1.big && !p2.big;
                r.address       = {p0.val, p1.val, p2.val, v[7:0]};
            end
        endcase
        if (!r.address_valid) begin
            r.address = '0;
        end
        return r;
    endfunction

    ipv4p_pkg::t_phase r_phase, n_phase;
    ipv4p_pkg::t_radix r_radix, n_radix;
    logic [31:0]       r_num, n_num;
    ipv4p_pkg::t_part  r_parts [3];
    ipv4p_pkg::t_part  n_parts [3];
    logic [1:0]        r_cnt, n_cnt;
    ipv4p_pkg::t_out   r_dec, n_dec;

    ipv4p_pkg::t_out   r_oq [ipv4p_pkg::OUT_DEPTH];
    logic [ipv4p_pkg::OUT_AW-1:0] r_owp, r_orp;
    logic [ipv4p_pkg::OCNT_W-1:0] r_ocnt, n_ocnt;

    ipv4p_pkg::t_radix w_eff_radix;
    logic [31:0]       w_mac;
    logic [31:0]       w_dig;
    logic              w_numchar;
    logic              w_decide;
    ipv4p_pkg::t_out   w_dec_val;
    ipv4p_pkg::t_out   w_asm_cur;
    ipv4p_pkg::t_out   w_res;
    logic              w_emit;
    logic              w_step;
    logic              w_opop;

    assign empty  = (r_ocnt == '0);
    assign o_res  = r_oq[r_orp];
    assign w_opop = pop && !empty;
    assign w_step = i_q_valid &&
                    ((r_ocnt != ipv4p_pkg::OCNT_W'(ipv4p_pkg::OUT_DEPTH)) || w_opop);
    assign o_take = w_step;
    assign w_dig  = {28'd0, i_item.val};

    assign w_eff_radix = (r_phase == ipv4p_pkg::PH_ZERO) ? ipv4p_pkg::RX_OCT : r_radix;

    always_comb begin
        case (w_eff_radix)
            ipv4p_pkg::RX_OCT: w_mac = {r_num[28:0], 3'b000} + w_dig;
            ipv4p_pkg::RX_HEX: w_mac = {r_num[27:0], i_item.val};
            default:           w_mac = {r_num[28:0], 3'b000} + {r_num[30:0], 1'b0} + w_dig;
        endcase
    end

    assign w_asm_cur = assemble(r_num, r_parts[0], r_parts[1], r_parts[2], r_cnt);

    always_comb begin
        n_phase   = r_phase;
        n_radix   = r_radix;
        n_num     = r_num;
        n_parts   = r_parts;
        n_cnt     = r_cnt;
        w_numchar = 1'b0;
        w_decide  = 1'b0;
        w_dec_val = '0;
        case (r_phase)
            ipv4p_pkg::PH_START: begin
                if (i_item.cls != ipv4p_pkg::CL_DIGIT) begin
                    w_decide = 1'b1;
                end else if (i_item.val == 4'd0) begin
                    n_num   = '0;
                    n_radix = ipv4p_pkg::RX_OCT;
                    n_phase = ipv4p_pkg::PH_ZERO;
                end else begin
                    n_num   = w_dig;
                    n_radix = ipv4p_pkg::RX_DEC;
                    n_phase = ipv4p_pkg::PH_NUM;
                end
            end
            ipv4p_pkg::PH_ZERO: begin
                n_phase = ipv4p_pkg::PH_NUM;
                if (i_item.cls == ipv4p_pkg::CL_X) begin
                    n_radix = ipv4p_pkg::RX_HEX;
                end else begin
                    n_radix   = ipv4p_pkg::RX_OCT;
                    w_numchar = 1'b1;
                end
            end
            ipv4p_pkg::PH_NUM: begin
                w_numchar = 1'b1;
            end
            default: begin
            end
        endcase

        if (w_numchar) begin
            case (i_item.cls)
                ipv4p_pkg::CL_DIGIT: begin
                    n_num = w_mac;
                end
                ipv4p_pkg::CL_HEXLET: begin
                    if (w_eff_radix == ipv4p_pkg::RX_HEX) begin
                        n_num = w_mac;
                    end else begin
                        w_decide = 1'b1;
                    end
                end
                ipv4p_pkg::CL_DOT: begin
                    if (r_cnt == 2'd3) begin
                        w_decide = 1'b1;
                    end else begin
                        n_parts[r_cnt] = '{big: (r_num[31:8] != '0), val: r_num[7:0]};
                        n_cnt          = r_cnt + 2'd1;
                        n_phase        = ipv4p_pkg::PH_START;
                    end
                end
                ipv4p_pkg::CL_END: begin
                    w_decide  = 1'b1;
                    w_dec_val = w_asm_cur;
                end
                default: begin
                    w_decide = 1'b1;
                end
            endcase
        end

        n_dec = r_dec;
        if (w_decide) begin
            n_phase = ipv4p_pkg::PH_DONE;
            n_dec   = w_dec_val;
        end

        w_emit = 1'b0;
        w_res  = '0;
        if (i_item.last) begin
            w_emit = 1'b1;
            if (n_phase == ipv4p_pkg::PH_DONE) begin
                w_res = n_dec;
            end else if (n_phase == ipv4p_pkg::PH_ZERO || n_phase == ipv4p_pkg::PH_NUM) begin
                w_res = assemble(n_num, n_parts[0], n_parts[1], n_parts[2], n_cnt);
            end
            n_phase = ipv4p_pkg::PH_START;
            n_radix = ipv4p_pkg::RX_DEC;
            n_num   = '0;
            n_cnt   = '0;
        end

        if (!w_step) begin
            n_phase = r_phase;
            n_radix = r_radix;
            n_num   = r_num;
            n_parts = r_parts;
            n_cnt   = r_cnt;
            n_dec   = r_dec;
            w_emit  = 1'b0;
        end
    end

    always_comb begin
        n_ocnt = r_ocnt;
        if (w_emit && !w_opop) begin
            n_ocnt = r_ocnt + 1'b1;
        end else if (w_opop && !w_emit) begin
            n_ocnt = r_ocnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ipv4p_pkg::PH_START;
            r_cnt   <= '0;
            r_ocnt  <= '0;
            r_owp   <= '0;
            r_orp   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_ocnt  <= n_ocnt;
            if (w_emit) begin
                r_owp <= (r_owp == ipv4p_pkg::OUT_AW'(ipv4p_pkg::OUT_DEPTH - 1)) ?
                         '0 : r_owp + 1'b1;
            end
            if (w_opop) begin
                r_orp <= (r_orp == ipv4p_pkg::OUT_AW'(ipv4p_pkg::OUT_DEPTH - 1)) ?
                         '0 : r_orp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_radix <= n_radix;
        r_num   <= n_num;
        r_parts <= n_parts;
        r_dec   <= n_dec;
        if (w_emit) begin
            r_oq[r_owp] <= w_res;
        end
    end

endmodule

### verif/ipv4_dotted_text_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_dotted_text_parser_tb
// Streams address text one character per request into the parser and checks
// every popped result against a built-in predictor of the dotted-quad parse.
// Covers directed edge forms, then mostly well-formed random addresses mixed
// with noise, broken strings and a long output stall.
// ----------------------------------------------------------------------------
module ipv4_dotted_text_parser_tb;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_CHARS   = 1100;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 10;

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            push    = 1'b0;
    ipv4p_pkg::t_in  i_req   = '0;
    logic            pop     = 1'b0;
    logic            full;
    logic            empty;
    ipv4p_pkg::t_out o_res;

    ipv4_dotted_text_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_req   (i_req),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );

    // Predicted parser state
    logic [31:0]       run_num;
    ipv4p_pkg::t_radix run_radix;
    logic [31:0]       prior_part [3];
    logic [1:0]        prior_cnt;
    ipv4p_pkg::t_phase run_phase;
    bit                verdict_set;
    bit                verdict_ok;
    logic [31:0]       verdict_addr;

    ipv4p_pkg::t_out expected_addr_q [$];
    logic [7:0]      text_q [$];
    int              err_cnt    = 0;
    int              sent_chars = 0;
    int              burst_left = 0;
    int              cycle_cnt  = 0;
    bit              gapless    = 1'b0;
    bit              hold_ask   = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("ipv4_dotted_text_parser verification failed");
            $finish;
        end
    end

    function automatic bit is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0b ||
               c == 8'h0c || c == 8'h0d;
    endfunction

    function automatic void parse_clear();
        run_num      = '0;
        run_radix    = ipv4p_pkg::RX_DEC;
        prior_part   = '{default: '0};
        prior_cnt    = '0;
        run_phase    = ipv4p_pkg::PH_START;
        verdict_set  = 1'b0;
        verdict_ok   = 1'b0;
        verdict_addr = '0;
    endfunction

    function automatic void parse_settle(bit ok, logic [31:0] addr);
        verdict_set  = 1'b1;
        verdict_ok   = ok;
        verdict_addr = ok ? addr : 32'd0;
    endfunction

    function automatic void parse_assemble();
        logic [31:0] p0, p1, p2;
        p0 = prior_part[0];
        p1 = prior_part[1];
        p2 = prior_part[2];
        case (prior_cnt)
            2'd0: parse_settle(1'b1, run_num);
            2'd1: begin
                if (run_num > 32'hffffff || p0 > 32'hff) parse_settle(1'b0, '0);
                else parse_settle(1'b1, run_num | (p0 << 24));
            end
            2'd2: begin
                if (run_num > 32'hffff || p0 > 32'hff || p1 > 32'hff) parse_settle(1'b0, '0);
                else parse_settle(1'b1, run_num | (p0 << 24) | (p1 << 16));
            end
            default: begin
                if (run_num > 32'hff || p0 > 32'hff || p1 > 32'hff || p2 > 32'hff)
                    parse_settle(1'b0, '0);
                else
                    parse_settle(1'b1, run_num | (p0 << 24) | (p1 << 16) | (p2 << 8));
            end
        endcase
    endfunction

    function automatic void parse_number_char(logic [7:0] c);
        logic [31:0] base;
        logic [31:0] code;
        code = {24'd0, c};
        if (is_digit(c)) begin
            base = (run_radix == ipv4p_pkg::RX_OCT) ? 32'd8 :
                   (run_radix == ipv4p_pkg::RX_HEX) ? 32'd16 : 32'd10;
            run_num = run_num * base + (code - 32'h30);
        end else if (run_radix == ipv4p_pkg::RX_HEX && c >= 8'h61 && c <= 8'h66) begin
            run_num = (run_num << 4) | (code - 32'h61 + 32'd10);
        end else if (run_radix == ipv4p_pkg::RX_HEX && c >= 8'h41 && c <= 8'h46) begin
            run_num = (run_num << 4) | (code - 32'h41 + 32'd10);
        end else if (c == 8'h2e) begin
            if (prior_cnt == 2'd3) begin
                parse_settle(1'b0, '0);
            end else begin
                prior_part[prior_cnt] = run_num;
                prior_cnt = prior_cnt + 2'd1;
                run_phase = ipv4p_pkg::PH_START;
            end
        end else if (c == 8'h00 || is_space(c)) begin
            parse_assemble();
        end else begin
            parse_settle(1'b0, '0);
        end
    endfunction

    function automatic void parse_char(logic [7:0] c);
        if (run_phase == ipv4p_pkg::PH_ZERO) begin
            if (c == 8'h78 || c == 8'h58) begin
                run_radix = ipv4p_pkg::RX_HEX;
                run_phase = ipv4p_pkg::PH_NUM;
            end else begin
                run_radix = ipv4p_pkg::RX_OCT;
                run_phase = ipv4p_pkg::PH_NUM;
                parse_number_char(c);
            end
        end else if (run_phase == ipv4p_pkg::PH_NUM) begin
            parse_number_char(c);
        end else if (!is_digit(c)) begin
            parse_settle(1'b0, '0);
        end else if (c == 8'h30) begin
            run_num   = '0;
            run_radix = ipv4p_pkg::RX_OCT;
            run_phase = ipv4p_pkg::PH_ZERO;
        end else begin
            run_num   = {24'd0, c} - 32'h30;
            run_radix = ipv4p_pkg::RX_DEC;
            run_phase = ipv4p_pkg::PH_NUM;
        end
    endfunction

    function automatic void predict_address(logic [7:0] c, logic is_last);
        ipv4p_pkg::t_out res;
        if (!verdict_set) parse_char(c);
        if (is_last) begin
            if (!verdict_set) begin
                if (run_phase == ipv4p_pkg::PH_ZERO || run_phase == ipv4p_pkg::PH_NUM)
                    parse_assemble();
                else
                    parse_settle(1'b0, '0);
            end
            res.address_valid = verdict_ok;
            res.address       = verdict_addr;
            expected_addr_q.push_back(res);
            parse_clear();
        end
    endfunction

    task automatic send_char(input logic [7:0] c, input logic is_last);
        int gap;
        ipv4p_pkg::t_in req;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req.char_code = c;
        req.last_char = is_last;
        push  <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (full);
        sent_chars++;
        predict_address(c, is_last);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_char(text_q[i], i == text_q.size() - 1);
    endtask

    function automatic void append_text(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 5))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0a;
            3: return 8'h0b;
            4: return 8'h0c;
            default: return 8'h0d;
        endcase
    endfunction

    function automatic void append_number(longint unsigned v);
        string s;
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: append_text($sformatf("%0d", v));
            1: append_text($sformatf("0%0o", v));
            2: begin
                append_text($urandom_range(0, 1) ? "0x" : "0X");
                if (v != 0 || $urandom_range(0, 1)) begin
                    s = $sformatf("%0h", v);
                    for (int i = 0; i < s.len(); i++) begin
                        c = s[i];
                        if (c >= 8'h61 && $urandom_range(0, 1)) c = c - 8'h20;
                        text_q.push_back(c);
                    end
                end
            end
            default: append_text($sformatf("0%0d", v));  // octal prefix on decimal digits, which may include 8 and 9
        endcase
    endfunction

    function automatic longint unsigned pick_value(longint unsigned lim);
        case ($urandom_range(0, 9))
            0: return lim;
            1: return lim + 1 + $urandom_range(0, 3);
            2: return 0;
            3: return {$urandom, $urandom} & 64'h1_ffff_ffff;
            default: return $urandom_range(0, 32'(lim));
        endcase
    endfunction

    function automatic void build_random_text();
        int kind, nparts;
        longint unsigned lim;
        text_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom));
            return;
        end
        nparts = $urandom_range(1, 4);
        for (int p = 0; p < nparts; p++) begin
            if (p > 0) text_q.push_back(8'h2e);
            if (p < nparts - 1) lim = 64'hff;
            else lim = 64'hffff_ffff >> (8 * (nparts - 1));
            append_number(pick_value(lim));
        end
        case ($urandom_range(0, 8))
            6: begin
                text_q.push_back(pick_space());
                repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom));
            end
            7: begin
                text_q.push_back(8'h00);
                repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom));
            end
            8: text_q.push_back(pick_space());
            default: ;
        endcase
        if (kind >= 80) begin
            case ($urandom_range(0, 4))
                0: text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom);
                1: text_q.push_back(8'h2e);
                2: if (text_q.size() > 1) void'(text_q.pop_back());
                3: text_q.insert($urandom_range(0, text_q.size()), 8'h2e);
                default: append_text(".7");
            endcase
        end
    endfunction

    task automatic test_directed_forms();
        string forms [$];
        forms = '{"0", "255.255.255.255", "0.0.0.0", "4294967295", "4294967296",
                  "0xffffffff", "0XABCDEF", "0x", "0x.1", "017", "089",
                  "1.16777215", "1.16777216", "1.2.65535", "1.2.65536", "256.1",
                  "1.2.3.4.5", "1.2.3.", ".1", "1.2.3.4 junk", "1a", "0x1g",
                  "1.2.3.256", "00x1"};
        foreach (forms[i]) begin
            text_q.delete();
            append_text(forms[i]);
            send_text();
        end
        // NUL inside the number, then characters that are ignored
        text_q.delete();
        append_text("1.2");
        text_q.push_back(8'h00);
        text_q.push_back(8'hff);
        text_q.push_back(8'h80);
        send_text();
        // lone NUL as the whole text
        text_q.delete();
        text_q.push_back(8'h00);
        send_text();
    endtask

    task automatic test_output_stall();
        hold_ask = 1'b1;
        gapless  = 1'b1;
        repeat (40) begin
            build_random_text();
            send_text();
        end
        gapless = 1'b0;
    endtask

    task automatic test_random_addresses();
        while (sent_chars < RANDOM_CHARS) begin
            build_random_text();
            send_text();
        end
    endtask

    initial begin : result_drain
        ipv4p_pkg::t_out want;
        int mode = 0;
        int mode_left = 0;
        int tick = 0;
        int hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (expected_addr_q.size() == 0) begin
                    $error("result with no request waiting: address_valid %0b address %h",
                           o_res.address_valid, o_res.address);
                    err_cnt++;
                end else begin
                    want = expected_addr_q.pop_front();
                    if (o_res.address_valid !== want.address_valid) begin
                        $error("address_valid expected %0b actual %0b",
                               want.address_valid, o_res.address_valid);
                        err_cnt++;
                    end
                    if (o_res.address !== want.address) begin
                        $error("address expected %h actual %h", want.address, o_res.address);
                        err_cnt++;
                    end
                end
            end
            if (hold_ask) begin
                hold_left = LONG_HOLD;
                hold_ask  = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                case (mode)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom_range(0, 1));
                    2: pop <= (tick % 4 == 0);
                    default: pop <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial begin
        parse_clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_forms();
        test_output_stall();
        test_random_addresses();
        push <= 1'b0;
        while (expected_addr_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && expected_addr_q.size() == 0) begin
            $display("ipv4_dotted_text_parser verification clean");
        end else begin
            $display("ipv4_dotted_text_parser verification failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/ipv4p_pkg.sv
rtl/ipv4p_front.sv
rtl/ipv4p_engine.sv
rtl/ipv4_dotted_text_parser.sv
verif/ipv4_dotted_text_parser_tb.sv
